>>> rtl/imhq_pkg.sv
package imhq_pkg;

  localparam int ID_W = 6;
  localparam int ID_COUNT = 64;
  localparam int KEY_W = 32;
  localparam int ST_W = 3;
  localparam int OP_W = 2;
  localparam int DEFAULT_CAPACITY = 64;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_CHANGE = 2'd1;
  localparam logic [OP_W-1:0] OP_EXTRACT = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 3'd2;
  localparam logic [ST_W-1:0] ST_ABSENT = 3'd3;
  localparam logic [ST_W-1:0] ST_PRESENT = 3'd4;

  // One heap slot: the id and key stored there.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } slot_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            accept;
    logic            dec;
    logic            ins_start;
    logic            ch_pos;
    logic            ex_eval;
    logic            up_rd;
    logic            up_eval;
    logic            dn_rd;
    logic            dn_eval;
    logic            place;
    logic            resp_load;
    logic [ST_W-1:0] status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic            full;
    logic            present;
    logic            empty;
    logic [OP_W-1:0] opcode;
    logic            pos_zero;
    logic            up_less;
    logic            dn_leaf;
    logic            dn_move;
    logic            old_lt;
    logic            old_gt;
    logic            last_out;
    logic            out_free;
  } stat_t;

endpackage

>>> rtl/imhq_in_if.sv
interface imhq_in_if;
  logic                             valid;
  logic                             ready;
  logic [imhq_pkg::OP_W-1:0]        opcode;
  logic [imhq_pkg::ID_W-1:0]        node_id;
  logic [imhq_pkg::KEY_W-1:0]       key;

  modport source (output valid, output opcode, output node_id, output key, input ready);
  modport sink (input valid, input opcode, input node_id, input key, output ready);
endinterface

>>> rtl/imhq_out_if.sv
interface imhq_out_if #(
  parameter int CNT_W = $clog2(imhq_pkg::DEFAULT_CAPACITY + 1)
);
  logic                        valid;
  logic                        ready;
  logic [imhq_pkg::ST_W-1:0]   status;
  logic [imhq_pkg::ID_W-1:0]   min_id;
  logic [imhq_pkg::KEY_W-1:0]  min_key;
  logic [CNT_W-1:0]            entry_count;
  logic                        is_member;

  modport source (output valid, output status, output min_id, output min_key,
                  output entry_count, output is_member, input ready);
  modport sink (input valid, input status, input min_id, input min_key,
                input entry_count, input is_member, output ready);
endinterface

>>> rtl/imhq_ctrl.sv
module imhq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  imhq_pkg::stat_t stat,
  output imhq_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_CH_POS = 4'd2;
  localparam logic [3:0] S_CH_OLD = 4'd3;
  localparam logic [3:0] S_EX     = 4'd4;
  localparam logic [3:0] S_UP     = 4'd5;
  localparam logic [3:0] S_UPCMP  = 4'd6;
  localparam logic [3:0] S_DN     = 4'd7;
  localparam logic [3:0] S_DNCMP  = 4'd8;
  localparam logic [3:0] S_PLACE  = 4'd9;
  localparam logic [3:0] S_RESP   = 4'd10;

  logic [3:0]                state_r, state_nxt;
  logic [imhq_pkg::ST_W-1:0] status_r, status_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and the command for the datapath.
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.status = status_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          status_nxt = imhq_pkg::ST_OK;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        cmd.dec = 1'b1;
        case (stat.opcode)
          imhq_pkg::OP_INSERT: begin
            if (stat.full) begin
              status_nxt = imhq_pkg::ST_FULL;
              state_nxt  = S_RESP;
            end else if (stat.present) begin
              status_nxt = imhq_pkg::ST_PRESENT;
              state_nxt  = S_RESP;
            end else begin
              cmd.ins_start = 1'b1;
              state_nxt     = S_UP;
            end
          end
          imhq_pkg::OP_CHANGE: begin
            if (!stat.present) begin
              status_nxt = imhq_pkg::ST_ABSENT;
              state_nxt  = S_RESP;
            end else begin
              state_nxt = S_CH_POS;
            end
          end
          imhq_pkg::OP_EXTRACT: begin
            if (stat.empty) begin
              status_nxt = imhq_pkg::ST_EMPTY;
              state_nxt  = S_RESP;
            end else begin
              state_nxt = S_EX;
            end
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_CH_POS: begin
        cmd.ch_pos = 1'b1;
        state_nxt  = S_CH_OLD;
      end
      S_CH_OLD: begin
        if (stat.old_lt) begin
          state_nxt = S_DN;
        end else if (stat.old_gt) begin
          state_nxt = S_UP;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_EX: begin
        cmd.ex_eval = 1'b1;
        state_nxt   = stat.last_out ? S_RESP : S_DN;
      end
      S_UP: begin
        cmd.up_rd = 1'b1;
        state_nxt = stat.pos_zero ? S_PLACE : S_UPCMP;
      end
      S_UPCMP: begin
        cmd.up_eval = 1'b1;
        state_nxt   = stat.up_less ? S_UP : S_PLACE;
      end
      S_DN: begin
        cmd.dn_rd = 1'b1;
        state_nxt = stat.dn_leaf ? S_PLACE : S_DNCMP;
      end
      S_DNCMP: begin
        cmd.dn_eval = 1'b1;
        state_nxt   = stat.dn_move ? S_DN : S_PLACE;
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.resp_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= imhq_pkg::ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

>>> rtl/imhq_dp.sv
module imhq_dp #(
  parameter int CAPACITY = imhq_pkg::DEFAULT_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [imhq_pkg::OP_W-1:0]  in_opcode,
  input  logic [imhq_pkg::ID_W-1:0]  in_node_id,
  input  logic [imhq_pkg::KEY_W-1:0] in_key,
  input  imhq_pkg::cmd_t             cmd,
  output imhq_pkg::stat_t            stat,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [imhq_pkg::ST_W-1:0]  out_status,
  output logic [imhq_pkg::ID_W-1:0]  out_min_id,
  output logic [imhq_pkg::KEY_W-1:0] out_min_key,
  output logic [CNT_W-1:0]           out_entry_count,
  output logic                       out_is_member
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = IW + 2;

  // Heap slots and the id-to-slot table.
  imhq_pkg::slot_t         heap_mem [CAPACITY];
  logic [IW-1:0]           pos_mem  [imhq_pkg::ID_COUNT];
  logic [imhq_pkg::ID_COUNT-1:0] present_r;

  imhq_pkg::slot_t         rd_a_r, rd_b_r;
  logic [IW-1:0]           pos_rd_r;
  logic [IW-1:0]           ra_addr, rb_addr;

  logic [imhq_pkg::OP_W-1:0]  op_r;
  logic [imhq_pkg::ID_W-1:0]  req_id_r;
  logic [imhq_pkg::ID_W-1:0]  mov_id_r;
  logic [imhq_pkg::KEY_W-1:0] mov_key_r;
  logic [imhq_pkg::ID_W-1:0]  min_id_r;
  logic [imhq_pkg::KEY_W-1:0] min_key_r;
  logic [IW-1:0]              pos_r;
  logic [CNT_W-1:0]           count_r;

  logic [IW-1:0]   par;
  logic [LW-1:0]   lch, rch, count_x;
  logic            r_ok;
  logic            pick_right;
  imhq_pkg::slot_t child;
  logic [IW-1:0]   child_idx;
  logic [CNT_W-1:0] last_idx;

  // Parent and child slots of the current position.
  assign par        = IW'((pos_r - 1'b1) >> 1);
  assign lch        = LW'({pos_r, 1'b0}) | LW'(1);
  assign rch        = lch + LW'(1);
  assign count_x    = LW'(count_r);
  assign r_ok       = (rch < count_x);
  assign pick_right = r_ok && (rd_b_r.key < rd_a_r.key);
  assign child      = pick_right ? rd_b_r : rd_a_r;
  assign child_idx  = pick_right ? rch[IW-1:0] : lch[IW-1:0];
  assign last_idx   = count_r - CNT_W'(1);

  // Read addresses of the heap memory for each step.
  always_comb begin
    ra_addr = '0;
    rb_addr = '0;
    if (cmd.dec) begin
      rb_addr = last_idx[IW-1:0];
    end else if (cmd.ch_pos) begin
      ra_addr = pos_rd_r;
    end else if (cmd.up_rd) begin
      ra_addr = par;
    end else if (cmd.dn_rd) begin
      ra_addr = lch[IW-1:0];
      rb_addr = r_ok ? rch[IW-1:0] : lch[IW-1:0];
    end
  end

  // Heap memory: two registered reads and one write a cycle.
  always_ff @(posedge clk) begin
    rd_a_r <= heap_mem[ra_addr];
    rd_b_r <= heap_mem[rb_addr];
    if (cmd.up_eval && stat.up_less) begin
      heap_mem[pos_r] <= rd_a_r;
    end else if (cmd.dn_eval && stat.dn_move) begin
      heap_mem[pos_r] <= child;
    end else if (cmd.place) begin
      heap_mem[pos_r] <= '{id: mov_id_r, key: mov_key_r};
    end
  end

  // Slot table: read at the requested id, written as entries move.
  always_ff @(posedge clk) begin
    pos_rd_r <= pos_mem[req_id_r];
    if (cmd.up_eval && stat.up_less) begin
      pos_mem[rd_a_r.id] <= pos_r;
    end else if (cmd.dn_eval && stat.dn_move) begin
      pos_mem[child.id] <= pos_r;
    end else if (cmd.place) begin
      pos_mem[mov_id_r] <= pos_r;
    end
  end

  // Control state: presence bits, count and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.ins_start) begin
        present_r[req_id_r] <= 1'b1;
        count_r             <= count_r + CNT_W'(1);
      end else if (cmd.ex_eval) begin
        present_r[rd_a_r.id] <= 1'b0;
        count_r              <= last_idx;
      end
      if (cmd.resp_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers of the operation in flight.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r      <= in_opcode;
      req_id_r  <= in_node_id;
      mov_id_r  <= in_node_id;
      mov_key_r <= in_key;
      min_id_r  <= '0;
      min_key_r <= '0;
    end
    if (cmd.ins_start) begin
      pos_r <= count_r[IW-1:0];
    end
    if (cmd.ch_pos) begin
      pos_r <= pos_rd_r;
    end
    if (cmd.ex_eval) begin
      min_id_r  <= rd_a_r.id;
      min_key_r <= rd_a_r.key;
      mov_id_r  <= rd_b_r.id;
      mov_key_r <= rd_b_r.key;
      pos_r     <= '0;
    end
    if (cmd.up_eval && stat.up_less) begin
      pos_r <= par;
    end
    if (cmd.dn_eval && stat.dn_move) begin
      pos_r <= child_idx;
    end
    if (cmd.resp_load) begin
      out_status      <= cmd.status;
      out_min_id      <= min_id_r;
      out_min_key     <= min_key_r;
      out_entry_count <= count_r;
      out_is_member   <= present_r[req_id_r];
    end
  end

  // Status for the controller.
  always_comb begin
    stat          = '0;
    stat.opcode   = op_r;
    stat.full     = (count_r == CNT_W'(CAPACITY));
    stat.present  = present_r[req_id_r];
    stat.empty    = (count_r == '0);
    stat.pos_zero = (pos_r == '0);
    stat.up_less  = (mov_key_r < rd_a_r.key);
    stat.dn_leaf  = (lch >= count_x);
    stat.dn_move  = (mov_key_r > child.key);
    stat.old_lt   = (rd_a_r.key < mov_key_r);
    stat.old_gt   = (rd_a_r.key > mov_key_r);
    stat.last_out = (count_r == CNT_W'(1));
    stat.out_free = !out_valid || out_ready;
  end

endmodule

>>> rtl/indexed_min_heap_queue.sv
// Indexed binary min-heap priority queue for node ids 0 to 63 with 32-bit
// unsigned keys, smaller first. One operation is taken per transfer and one
// result returned for it. A query or a rejected operation goes from the decode
// step straight to the response. Otherwise the entry moves level by level, up
// or down, until it ends at the root, at a leaf or in its place. Each level is
// one registered read of the heap memory followed by a compare and write back.
// No clearing pass is needed after reset. A result register parts the two
// sides, so a new item is accepted while the previous result still waits; that
// item then holds in its last cycle until the waiting result has been taken.
module indexed_min_heap_queue #(
  parameter int CAPACITY = imhq_pkg::DEFAULT_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic        clk,
  input  logic        rst_n,
  imhq_in_if.sink     in_ch,
  imhq_out_if.source  out_ch
);

  imhq_pkg::cmd_t  cmd;
  imhq_pkg::stat_t stat;

  imhq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  imhq_dp #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_ch.opcode),
    .in_node_id      (in_ch.node_id),
    .in_key          (in_ch.key),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_min_id      (out_ch.min_id),
    .out_min_key     (out_ch.min_key),
    .out_entry_count (out_ch.entry_count),
    .out_is_member   (out_ch.is_member)
  );

endmodule

>>> rtl/imhq_checker.sv
module imhq_checker #(
  parameter int CAPACITY = imhq_pkg::DEFAULT_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [imhq_pkg::ST_W-1:0]  out_status,
  input logic [imhq_pkg::ID_W-1:0]  out_min_id,
  input logic [imhq_pkg::KEY_W-1:0] out_min_key,
  input logic [CNT_W-1:0]           out_entry_count
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_min_key))
    else $error("result dropped while stalled");

  // The count never exceeds the capacity.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // A rejected operation reports no removed entry.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != imhq_pkg::ST_OK |-> out_min_id == '0 && out_min_key == '0)
    else $error("removed entry reported on a rejected operation");

  // An empty heap reports a zero count; a full one reports the capacity.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == imhq_pkg::ST_EMPTY |-> out_entry_count == '0)
    else $error("empty status with entries left");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == imhq_pkg::ST_FULL |-> out_entry_count == CNT_W'(CAPACITY))
    else $error("full status below capacity");

endmodule

bind indexed_min_heap_queue imhq_checker #(
  .CAPACITY (CAPACITY),
  .CNT_W    (CNT_W)
) u_imhq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_min_id      (out_ch.min_id),
  .out_min_key     (out_ch.min_key),
  .out_entry_count (out_ch.entry_count)
);

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int CAP = imhq_pkg::DEFAULT_CAPACITY;
  localparam int CNT_W = $clog2(CAP + 1);
  localparam int ID_W = imhq_pkg::ID_W;
  localparam int KEY_W = imhq_pkg::KEY_W;
  localparam int OP_W = imhq_pkg::OP_W;
  localparam int ID_COUNT = imhq_pkg::ID_COUNT;

  typedef struct packed {
    logic [imhq_pkg::ST_W-1:0] status;
    logic [ID_W-1:0]  min_id;
    logic [KEY_W-1:0] min_key;
    logic [CNT_W-1:0] entry_count;
    logic             is_member;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  imhq_in_if in_ch ();
  imhq_out_if #(.CNT_W(CNT_W)) out_ch ();

  indexed_min_heap_queue #(.CAPACITY(CAP), .CNT_W(CNT_W)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // Predicted heap contents, kept in the same order the block keeps them.
  logic [KEY_W-1:0] heap_key [CAP];
  logic [ID_W-1:0]  heap_id [CAP];
  int               id_pos [ID_COUNT];
  bit               id_in [ID_COUNT];
  int               heap_size;

  heap_result_t expected_q [$];
  int  error_count;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_cycles;
  int  result_count;

  function automatic void heap_put(int pos, logic [ID_W-1:0] id, logic [KEY_W-1:0] k);
    heap_key[pos] = k;
    heap_id[pos] = id;
    id_pos[id] = pos;
  endfunction

  function automatic void heap_up(int pos);
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] k;
    int par;
    id = heap_id[pos];
    k = heap_key[pos];
    while (pos > 0) begin
      par = (pos - 1) / 2;
      if (!(k < heap_key[par])) break;
      heap_put(pos, heap_id[par], heap_key[par]);
      pos = par;
    end
    heap_put(pos, id, k);
  endfunction

  function automatic void heap_down(int pos);
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] k;
    int l;
    int c;
    id = heap_id[pos];
    k = heap_key[pos];
    forever begin
      l = 2 * pos + 1;
      if (l >= heap_size) break;
      c = l;
      if (l + 1 < heap_size && heap_key[l + 1] < heap_key[l]) c = l + 1;
      if (!(k > heap_key[c])) break;
      heap_put(pos, heap_id[c], heap_key[c]);
      pos = c;
    end
    heap_put(pos, id, k);
  endfunction

  // Apply one operation to the predicted heap and return its result.
  function automatic heap_result_t heap_apply(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                              logic [KEY_W-1:0] k);
    heap_result_t r;
    logic [KEY_W-1:0] old;
    int pos;
    r = '0;
    r.status = imhq_pkg::ST_OK;
    case (op)
      imhq_pkg::OP_INSERT: begin
        if (heap_size >= CAP) r.status = imhq_pkg::ST_FULL;
        else if (id_in[id]) r.status = imhq_pkg::ST_PRESENT;
        else begin
          heap_put(heap_size, id, k);
          id_in[id] = 1'b1;
          heap_size++;
          heap_up(heap_size - 1);
        end
      end
      imhq_pkg::OP_CHANGE: begin
        if (!id_in[id]) r.status = imhq_pkg::ST_ABSENT;
        else begin
          pos = id_pos[id];
          old = heap_key[pos];
          heap_key[pos] = k;
          if (old < k) heap_down(pos);
          else if (old > k) heap_up(pos);
        end
      end
      imhq_pkg::OP_EXTRACT: begin
        if (heap_size == 0) r.status = imhq_pkg::ST_EMPTY;
        else begin
          r.min_id = heap_id[0];
          r.min_key = heap_key[0];
          id_in[heap_id[0]] = 1'b0;
          heap_size--;
          if (heap_size > 0) begin
            heap_put(0, heap_id[heap_size], heap_key[heap_size]);
            heap_down(0);
          end
        end
      end
      default: ;
    endcase
    r.entry_count = CNT_W'(heap_size);
    r.is_member = id_in[id];
    return r;
  endfunction

  // Offer one item, hold it until the transfer and record the prediction.
  // Valid stays high after the transfer unless the sender idles or drains.
  task automatic send_op(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic [KEY_W-1:0] k);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.node_id <= id;
    in_ch.key <= k;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(heap_apply(op, id, k));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  // Receiver readiness: random stalls, or a long hold when asked.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    heap_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_count++;
      if (expected_q.size() == 0) begin
        $error("result with no prediction waiting");
        error_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_ch.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_ch.status);
          error_count++;
        end
        if (out_ch.min_id !== exp_r.min_id) begin
          $error("min_id expected %0d actual %0d", exp_r.min_id, out_ch.min_id);
          error_count++;
        end
        if (out_ch.min_key !== exp_r.min_key) begin
          $error("min_key expected %0h actual %0h", exp_r.min_key, out_ch.min_key);
          error_count++;
        end
        if (out_ch.entry_count !== exp_r.entry_count) begin
          $error("entry_count expected %0d actual %0d", exp_r.entry_count,
                 out_ch.entry_count);
          error_count++;
        end
        if (out_ch.is_member !== exp_r.is_member) begin
          $error("is_member expected %0d actual %0d", exp_r.is_member, out_ch.is_member);
          error_count++;
        end
      end
    end
  end

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(7);
      default: return $urandom();
    endcase
  endfunction

  // Edge cases: empty, rejections, equal keys, full heap and key extremes.
  task automatic test_directed();
    send_op(imhq_pkg::OP_EXTRACT, 6'd0, '0);
    send_op(imhq_pkg::OP_QUERY, 6'd63, '1);
    send_op(imhq_pkg::OP_CHANGE, 6'd5, 32'd1);
    send_op(imhq_pkg::OP_INSERT, 6'd63, '1);
    send_op(imhq_pkg::OP_INSERT, 6'd0, '0);
    send_op(imhq_pkg::OP_INSERT, 6'd0, 32'd9);
    send_op(imhq_pkg::OP_INSERT, 6'd7, 32'd5);
    send_op(imhq_pkg::OP_INSERT, 6'd8, 32'd5);
    send_op(imhq_pkg::OP_INSERT, 6'd9, 32'd5);
    send_op(imhq_pkg::OP_CHANGE, 6'd7, 32'd5);
    send_op(imhq_pkg::OP_CHANGE, 6'd0, 32'd5);
    send_op(imhq_pkg::OP_CHANGE, 6'd63, '0);
    send_op(imhq_pkg::OP_CHANGE, 6'd9, 32'hAAAA_AAAA);
    send_op(imhq_pkg::OP_CHANGE, 6'd9, 32'h5555_5555);
    send_op(imhq_pkg::OP_QUERY, 6'd9, '0);
    send_op(imhq_pkg::OP_EXTRACT, 6'd42, '0);
    for (int i = 0; i < 6; i++) send_op(imhq_pkg::OP_EXTRACT, 6'd63, '0);
    for (int i = 0; i < ID_COUNT; i++) begin
      send_op(imhq_pkg::OP_INSERT, i[ID_W-1:0], 32'(ID_COUNT - i));
    end
    send_op(imhq_pkg::OP_INSERT, 6'd3, 32'd1);
    for (int i = 0; i < ID_COUNT + 1; i++) send_op(imhq_pkg::OP_EXTRACT, 6'd21, '0);
    wait_drained();
  endtask

  // Random traffic: all four operations, mostly extractions above 48 entries and mostly inserts and changes otherwise.
  task automatic test_random(int n_items);
    int p;
    logic [OP_W-1:0] op;
    for (int i = 0; i < n_items; i++) begin
      p = $urandom_range(99);
      if (heap_size > 48) begin
        op = (p < 55) ? imhq_pkg::OP_EXTRACT : (p < 75) ? imhq_pkg::OP_CHANGE
           : (p < 90) ? imhq_pkg::OP_INSERT : imhq_pkg::OP_QUERY;
      end else begin
        op = (p < 45) ? imhq_pkg::OP_INSERT : (p < 70) ? imhq_pkg::OP_CHANGE
           : (p < 90) ? imhq_pkg::OP_EXTRACT : imhq_pkg::OP_QUERY;
      end
      send_op(op, ID_W'($urandom()), pick_key());
    end
  endtask

  // Long receiver hold while items keep coming, so the input stalls.
  task automatic test_backpressure();
    hold_cycles = 300;
    test_random(40);
    wait_drained();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = imhq_pkg::OP_QUERY;
    in_ch.node_id = '0;
    in_ch.key = '0;
    out_ch.ready = 1'b0;
    hold_cycles = 0;
    error_count = 0;
    result_count = 0;
    heap_size = 0;
    for (int i = 0; i < ID_COUNT; i++) id_in[i] = 1'b0;
    send_idle_pct = 38;
    recv_idle_pct = 59;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(450);
    wait_drained();
    send_idle_pct = 59;
    recv_idle_pct = 38;
    test_random(450);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(400);
    wait_drained();
    repeat (40) @(posedge clk);

    $display("Covered all four operations with rejections, equal keys and full heap,");
    $display("%0d results checked under random and long receiver stalls.", result_count);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> indexed_min_heap_queue.f
rtl/imhq_pkg.sv
rtl/imhq_in_if.sv
rtl/imhq_out_if.sv
rtl/imhq_ctrl.sv
rtl/imhq_dp.sv
rtl/indexed_min_heap_queue.sv
rtl/imhq_checker.sv
sim/tb.sv
